[hdl/tce_pkg.sv]
// Shared types and constants for the text console engine.
package tce_pkg;

  localparam int IdxW  = 11;
  localparam int PosW  = 11;
  localparam int CellW = 16;
  localparam int CharW = 8;
  localparam int ColorW = 4;

  typedef enum logic [1:0] {
    CMD_PUT     = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_RECOLOR = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SW_FILL = 2'd0,
    SW_COPY = 2'd1,
    SW_PEEK = 2'd2
  } sweep_mode_t;

  typedef struct packed {
    logic        start;
    sweep_mode_t mode;
  } sweep_ctl_t;

  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  localparam logic [CharW-1:0] CH_NUL       = 8'h00;
  localparam logic [CharW-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CharW-1:0] CH_SPACE     = 8'h20;
  localparam logic [CharW-1:0] CH_BACKSPACE = 8'h7F;

  localparam logic [CellW-1:0] RESET_CELL = 16'h0720;
  localparam logic [ColorW-1:0] FG_RESET  = 4'd7;
  localparam logic [ColorW-1:0] BG_RESET  = 4'd0;

endpackage

[hdl/tce_store.sv]
// Cell store: one write port, one read port with registered read data.
module tce_store #(
  parameter int Depth = 2000,
  parameter int AW    = 11
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [tce_pkg::CellW-1:0]   wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [tce_pkg::CellW-1:0]   rd_data
);

  logic [tce_pkg::CellW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/tce_sweep.sv]
// Address walker: fills, copies with an OR mask, or peeks runs of cells.
module tce_sweep #(
  parameter int AW = 11,
  parameter int CW = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tce_pkg::sweep_ctl_t       ctl,
  input  logic [AW-1:0]             rd_base,
  input  logic [AW-1:0]             wr_base,
  input  logic [CW-1:0]             count,
  input  logic [tce_pkg::CellW-1:0] value,
  input  logic [tce_pkg::CellW-1:0] rdata,
  output logic                      idle,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [tce_pkg::CellW-1:0] wr_data
);

  logic                      busy, busy_next;
  logic                      pend, pend_next;
  tce_pkg::sweep_mode_t      mode;
  logic [AW-1:0]             rp, wp;
  logic [CW-1:0]             left, left_next;
  logic [tce_pkg::CellW-1:0] val;
  logic                      issue;

  always_comb begin
    issue     = busy && (left != '0);
    rd_en     = issue && (mode != tce_pkg::SW_FILL);
    wr_en     = (issue && (mode == tce_pkg::SW_FILL)) ||
                (pend && (mode == tce_pkg::SW_COPY));
    wr_data   = (mode == tce_pkg::SW_FILL) ? val : (rdata | val);
    left_next = issue ? left - CW'(1) : left;
    pend_next = rd_en;
    busy_next = ctl.start || (busy && ((left_next != '0) || pend_next));
  end

  assign idle    = !busy;
  assign rd_addr = rp;
  assign wr_addr = wp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
    end else begin
      busy <= busy_next;
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode <= ctl.mode;
      rp   <= rd_base;
      wp   <= wr_base;
      left <= count;
      val  <= value;
    end else begin
      if (rd_en) begin
        rp <= rp + AW'(1);
      end
      if (wr_en) begin
        wp <= wp + AW'(1);
      end
      left <= left_next;
    end
  end

endmodule

[hdl/tce_ctrl.sv]
// Command sequencer: cursor state, command decode and result register.
module tce_ctrl #(
  parameter int Columns = 80,
  parameter int Rows    = 25,
  parameter int AW      = 11,
  parameter int CW      = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [1:0]                  command,
  input  logic [tce_pkg::CharW-1:0]   char_code,
  input  logic [tce_pkg::IdxW-1:0]    cell_index,
  input  logic [tce_pkg::CellW-1:0]   attr,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [tce_pkg::PosW-1:0]    cursor_position,
  output logic [tce_pkg::CellW-1:0]   cell_data,
  output tce_pkg::sweep_ctl_t         sw_ctl,
  output logic [AW-1:0]               sw_rd_base,
  output logic [AW-1:0]               sw_wr_base,
  output logic [CW-1:0]               sw_count,
  output logic [tce_pkg::CellW-1:0]   sw_value,
  input  logic                        sw_idle,
  input  logic [tce_pkg::CellW-1:0]   rdata
);

  localparam int Cells = Rows * Columns;
  localparam int RW    = $clog2(Rows);
  localparam int ClW   = $clog2(Columns + 1);
  localparam int LW    = $clog2(Cells + 1);

  typedef enum logic [7:0] {
    ST_INIT      = 8'b0000_0001,
    ST_INIT_WAIT = 8'b0000_0010,
    ST_IDLE      = 8'b0000_0100,
    ST_PLAN      = 8'b0000_1000,
    ST_SCR_WAIT  = 8'b0001_0000,
    ST_FILL_WAIT = 8'b0010_0000,
    ST_OP_WAIT   = 8'b0100_0000,
    ST_RESP      = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  tce_pkg::cmd_t              cmd_q;
  logic [tce_pkg::CharW-1:0]  ch_q;
  logic [tce_pkg::IdxW-1:0]   idx_q;

  logic [RW-1:0]              row, nrow;
  logic [ClW-1:0]             col, ncol, wcol;
  logic                       do_write, do_scroll;
  logic [tce_pkg::CellW-1:0]  wval;

  logic                       put_pend;
  logic [AW-1:0]              put_addr;
  logic [tce_pkg::CellW-1:0]  put_val;
  logic                       peek;
  logic                       read_ok;

  logic [RW-1:0]              mul_row;
  logic [ClW-1:0]             mul_col;
  logic [LW-1:0]              lin;

  logic                       accept;
  logic                       out_free;
  logic                       last_row;
  logic [tce_pkg::CellW-1:0]  blank;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign last_row   = (row == RW'(Rows - 1));
  assign blank      = attr | {8'h00, tce_pkg::CH_SPACE};
  assign read_ok    = (32'(idx_q) < 32'(Cells));

  // One row*Columns+column unit: target cell while planning, cursor otherwise.
  assign mul_row = (state == ST_PLAN) ? nrow : row;
  assign mul_col = (state == ST_PLAN) ? wcol : col;
  assign lin     = LW'(mul_row) * LW'(Columns) + LW'(mul_col);

  // Cursor move for put_char.
  always_comb begin
    nrow      = row;
    ncol      = col;
    wcol      = col;
    do_write  = 1'b0;
    do_scroll = 1'b0;
    wval      = blank;
    if (cmd_q == tce_pkg::CMD_PUT) begin
      if (ch_q == tce_pkg::CH_BACKSPACE) begin
        if (col == '0) begin
          if (row != '0) begin
            nrow     = row - RW'(1);
            wcol     = ClW'(Columns - 1);
            ncol     = wcol;
            do_write = 1'b1;
          end
        end else begin
          wcol     = col - ClW'(1);
          ncol     = wcol;
          do_write = 1'b1;
        end
      end else if (ch_q == tce_pkg::CH_NEWLINE) begin
        ncol = '0;
        wcol = '0;
        if (last_row) begin
          do_scroll = 1'b1;
        end else begin
          nrow = row + RW'(1);
        end
      end else if (ch_q != tce_pkg::CH_NUL) begin
        if (col == ClW'(Columns)) begin
          wcol = '0;
          if (last_row) begin
            do_scroll = 1'b1;
          end else begin
            nrow = row + RW'(1);
          end
        end
        ncol     = wcol + ClW'(1);
        do_write = 1'b1;
        wval     = attr | {8'h00, ch_q};
      end
    end
  end

  // Sweep requests and state sequencing.
  always_comb begin
    state_next    = state;
    sw_ctl.start  = 1'b0;
    sw_ctl.mode   = tce_pkg::SW_FILL;
    sw_rd_base    = '0;
    sw_wr_base    = '0;
    sw_count      = '0;
    sw_value      = '0;
    unique case (state)
      ST_INIT: begin
        sw_ctl.start = 1'b1;
        sw_count     = CW'(Cells);
        sw_value     = tce_pkg::RESET_CELL;
        state_next   = ST_INIT_WAIT;
      end
      ST_INIT_WAIT: begin
        if (sw_idle) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_PLAN;
        end
      end
      ST_PLAN: begin
        unique case (cmd_q)
          tce_pkg::CMD_CLEAR: begin
            sw_ctl.start = 1'b1;
            sw_count     = CW'(Cells);
            sw_value     = blank;
            state_next   = ST_OP_WAIT;
          end
          tce_pkg::CMD_RECOLOR: begin
            sw_ctl.start = 1'b1;
            sw_ctl.mode  = tce_pkg::SW_COPY;
            sw_count     = CW'(Cells);
            sw_value     = attr;
            state_next   = ST_OP_WAIT;
          end
          tce_pkg::CMD_READ: begin
            if (read_ok) begin
              sw_ctl.start = 1'b1;
              sw_ctl.mode  = tce_pkg::SW_PEEK;
              sw_rd_base   = AW'(idx_q);
              sw_count     = CW'(1);
              state_next   = ST_OP_WAIT;
            end else begin
              state_next = ST_RESP;
            end
          end
          tce_pkg::CMD_PUT: begin
            if (do_scroll) begin
              // Move rows up first; the last row is blanked afterwards.
              sw_ctl.start = 1'b1;
              sw_ctl.mode  = tce_pkg::SW_COPY;
              sw_rd_base   = AW'(Columns);
              sw_count     = CW'((Rows - 1) * Columns);
              state_next   = ST_SCR_WAIT;
            end else if (do_write) begin
              sw_ctl.start = 1'b1;
              sw_wr_base   = AW'(lin);
              sw_count     = CW'(1);
              sw_value     = wval;
              state_next   = ST_OP_WAIT;
            end else begin
              state_next = ST_RESP;
            end
          end
          default: state_next = ST_RESP;
        endcase
      end
      ST_SCR_WAIT: begin
        if (sw_idle) begin
          sw_ctl.start = 1'b1;
          sw_wr_base   = AW'((Rows - 1) * Columns);
          sw_count     = CW'(Columns);
          sw_value     = blank;
          state_next   = ST_FILL_WAIT;
        end
      end
      ST_FILL_WAIT: begin
        if (sw_idle) begin
          if (put_pend) begin
            sw_ctl.start = 1'b1;
            sw_wr_base   = put_addr;
            sw_count     = CW'(1);
            sw_value     = put_val;
            state_next   = ST_OP_WAIT;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_OP_WAIT: begin
        if (sw_idle) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      row          <= '0;
      col          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_PLAN) begin
        row <= nrow;
        col <= ncol;
      end
      if ((state == ST_RESP) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= tce_pkg::cmd_t'(command);
      ch_q  <= char_code;
      idx_q <= cell_index;
    end
    if (state == ST_PLAN) begin
      put_pend <= do_write && do_scroll;
      put_addr <= AW'(lin);
      put_val  <= wval;
      peek     <= (cmd_q == tce_pkg::CMD_READ) && read_ok;
    end
    if ((state == ST_RESP) && out_free) begin
      cursor_position <= tce_pkg::PosW'(lin);
      cell_data       <= peek ? rdata : '0;
    end
  end

  ap_start_idle: assert property (@(posedge clk) disable iff (rst)
    sw_ctl.start |-> sw_idle)
    else $error("sweep started while busy");

  ap_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> sw_idle)
    else $error("sweep still running while taking items");

  ap_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(col) <= 32'(Columns)) && (32'(row) < 32'(Rows)))
    else $error("cursor out of range");

  ap_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_RESP))
    else $error("result loaded outside the response step");

endmodule

[hdl/text_console_engine.sv]
// Text console engine top level: config registers, sequencer, walker and cell store.
//
// Character-cell text console holding Rows x Columns 16-bit cells
// (character in bits 7:0, foreground in 11:8, background in 15:12). Each
// item is one command: put_char (backspace 0x7F, newline, NUL ignored,
// everything else printed with wrap and scroll), clear, recolor (OR the
// current attribute into every cell) or read_cell; every item yields one
// result with the cursor position and, for read_cell, the cell contents.
// All store traffic goes through one address walker with a single write
// port and one registered read port, so timing is set by that walker.
// Newline without scroll, NUL, backspace at the origin and a read past the
// store skip the walker; clear and recolor walk every cell, and a scroll
// copies rows up one cell per cycle, then blanks the last row. After reset
// a clearing pass loads every cell with a light gray space; item_stall
// stays high during it, configuration writes are taken.
// The result sits in an output register, so the next item may be accepted
// while a result still waits. Write the color registers only while idle.
module text_console_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              clk,
  input  logic                              rst,
  // Item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        command,
  input  logic [tce_pkg::CharW-1:0]         char_code,
  input  logic [tce_pkg::IdxW-1:0]          cell_index,
  // Result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [tce_pkg::PosW-1:0]          cursor_position,
  output logic [tce_pkg::CellW-1:0]         cell_data,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [tce_pkg::ColorW-1:0]        cfg_data
);

  localparam int Cells = ROWS * COLUMNS;
  localparam int AW    = $clog2(Cells);
  localparam int CW    = $clog2(Cells + 1);

  logic [tce_pkg::ColorW-1:0] fg, bg;
  logic [tce_pkg::CellW-1:0]  attr;

  tce_pkg::sweep_ctl_t        sw_ctl;
  logic [AW-1:0]              sw_rd_base, sw_wr_base;
  logic [CW-1:0]              sw_count;
  logic [tce_pkg::CellW-1:0]  sw_value;
  logic                       sw_idle;

  logic                       rd_en, wr_en;
  logic [AW-1:0]              rd_addr, wr_addr;
  logic [tce_pkg::CellW-1:0]  wr_data, rd_data;

  // Color registers are always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= tce_pkg::FG_RESET;
      bg <= tce_pkg::BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tce_pkg::CFG_FG: fg <= cfg_data;
        tce_pkg::CFG_BG: bg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Attribute bits of a cell: background over foreground, character clear.
  assign attr = {bg, fg, 8'h00};

  tce_ctrl #(
    .Columns (COLUMNS),
    .Rows    (ROWS),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .command         (command),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .attr            (attr),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .cursor_position (cursor_position),
    .cell_data       (cell_data),
    .sw_ctl          (sw_ctl),
    .sw_rd_base      (sw_rd_base),
    .sw_wr_base      (sw_wr_base),
    .sw_count        (sw_count),
    .sw_value        (sw_value),
    .sw_idle         (sw_idle),
    .rdata           (rd_data)
  );

  tce_sweep #(
    .AW (AW),
    .CW (CW)
  ) u_sweep (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sw_ctl),
    .rd_base (sw_rd_base),
    .wr_base (sw_wr_base),
    .count   (sw_count),
    .value   (sw_value),
    .rdata   (rd_data),
    .idle    (sw_idle),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  tce_store #(
    .Depth (Cells),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
